// ----- design/led_blink_digit_display_assert.svh -----
// Assertion macros shared by the LED blink digit display RTL.
// Each macro is empty when SYNTHESIS is defined.
`ifndef LED_BLINK_DIGIT_DISPLAY_ASSERT_SVH
`define LED_BLINK_DIGIT_DISPLAY_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset
`define LBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset
`define LBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define LBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/ledbd_pkg.sv -----
// Package for the LED blink digit display: item types, register reset
// values and the digit split helper. No dependencies.
package ledbd_pkg;

    // Operation codes of an input item
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_FLASH = 2'd0;
    localparam logic [1:0] REG_MINUS = 2'd1;
    localparam logic [1:0] REG_GAP   = 2'd2;

    // Register reset values
    localparam logic [15:0] FLASH_TICKS_RST = 16'd250;
    localparam logic [15:0] MINUS_TICKS_RST = 16'd500;
    localparam logic [15:0] GAP_TICKS_RST   = 16'd1000;

    // A ones digit of zero shows as this many flashes
    localparam logic [4:0] ZERO_FLASHES = 5'd10;

    typedef struct packed {
        logic       op;
        logic [7:0] value;
        logic       negative;
        logic       led_select;
    } t_in_item;

    typedef struct packed {
        logic led_alarm;
        logic led_thermo;
        logic busy_res;
        logic done_res;
    } t_out_item;

    // Tens digit of an 8-bit value: multiply by 205/2048 (exact below 1029)
    function automatic logic [4:0] tens_of(input logic [7:0] v);
        logic [15:0] prod;
        prod = {8'd0, v} * 16'd205;
        return prod[15:11];
    endfunction

    // Ones digit of an 8-bit value given its tens digit
    function automatic logic [3:0] ones_of(input logic [7:0] v, input logic [4:0] t);
        logic [7:0] tens_x10;
        logic [7:0] rem;
        tens_x10 = {t, 3'd0} + {2'd0, t, 1'b0};
        rem      = v - tens_x10;
        return rem[3:0];
    endfunction

endpackage

// ----- design/ledbd_if.sv -----
// Channel interfaces of the LED blink digit display: input items, result
// items and configuration writes. Depends on ledbd_pkg.
interface ledbd_in_if;
    logic               valid;
    logic               ready;
    ledbd_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ledbd_out_if;
    logic                 valid;
    logic                 ready;
    ledbd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ledbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/led_blink_digit_display.sv -----
// Top level of the LED blink digit display: phase sequencer, tick counter
// and two-entry result buffer. Depends on ledbd_pkg, ledbd_if.sv and the assert header.
//
// Usage:
//   i_in   : input items. op tick advances the display by one millisecond;
//            op start loads value, negative and led_select when idle and is
//            ignored while a sequence runs.
//   o_out  : one result item per input item: both LED levels, busy and a
//            done pulse on the tick that ends the final gap.
//   i_cfg  : register writes (0 flash_ticks, 1 minus_ticks, 2 gap_ticks),
//            always ready; other indexes are dropped.
// Output: each result is registered in r_out, or in the skid entry while o_out is stalled.
// Throughput: one item per cycle while i_in.ready is high; the next-state logic
//   of the phase sequencer and 16-bit tick counter is combinational.
// Stall: a result register plus one skid entry; i_in.ready falls only when
//   both hold results that the receiver has not taken. Nothing is lost.
// Reset: synchronous, active low; registers return to 250/500/1000 ticks,
//   the sequencer goes idle and both result slots are emptied.
`include "led_blink_digit_display_assert.svh"

module led_blink_digit_display (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ledbd_in_if.sink    i_in,
    ledbd_out_if.source o_out,
    ledbd_cfg_if.sink   i_cfg
);
    import ledbd_pkg::*;

    // Sequencer phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_MINUS     = 3'd1;
    localparam logic [2:0] PH_MINUS_GAP = 3'd2;
    localparam logic [2:0] PH_TENS      = 3'd3;
    localparam logic [2:0] PH_TENS_GAP  = 3'd4;
    localparam logic [2:0] PH_ONES      = 3'd5;
    localparam logic [2:0] PH_FINAL_GAP = 3'd6;

    logic [15:0] r_flash_ticks, r_minus_ticks, r_gap_ticks;

    logic [2:0]  r_phase,   n_phase;
    logic [15:0] r_cnt,     n_cnt;
    logic [4:0]  r_flashes, n_flashes;
    logic [4:0]  r_tens,    n_tens;
    logic [3:0]  r_ones,    n_ones;
    logic        r_choice,  n_choice;
    logic        r_lamp,    n_lamp;
    logic        n_done;

    t_out_item   r_out, r_skid, n_res;
    logic        r_out_valid, r_skid_valid;

    logic        in_acc, out_free;
    logic [15:0] cnt_inc;
    logic [4:0]  flashes_dec;
    logic [4:0]  start_tens;
    logic [3:0]  start_ones;
    logic        over_flash, over_minus, over_gap;
    logic        flash_phase, start_idle, out_quiet;

    // Accept while the skid entry is free
    assign i_in.ready  = !r_skid_valid;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_ticks <= FLASH_TICKS_RST;
            r_minus_ticks <= MINUS_TICKS_RST;
            r_gap_ticks   <= GAP_TICKS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FLASH: r_flash_ticks <= i_cfg.data;
                REG_MINUS: r_minus_ticks <= i_cfg.data;
                REG_GAP:   r_gap_ticks   <= i_cfg.data;
                default:   ;
            endcase
        end
    end

    // Period end tests; a wrapped count also ends the period
    assign cnt_inc     = r_cnt + 16'd1;
    assign over_flash  = (cnt_inc >= r_flash_ticks) || (cnt_inc == 16'd0);
    assign over_minus  = (cnt_inc >= r_minus_ticks) || (cnt_inc == 16'd0);
    assign over_gap    = (cnt_inc >= r_gap_ticks)   || (cnt_inc == 16'd0);
    assign flashes_dec = (r_flashes != 5'd0) ? r_flashes - 5'd1 : 5'd0;
    assign start_tens  = tens_of(i_in.data.value);
    assign start_ones  = ones_of(i_in.data.value, start_tens);

    // Next state of the sequencer for the item at the input
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_flashes = r_flashes;
        n_tens    = r_tens;
        n_ones    = r_ones;
        n_choice  = r_choice;
        n_lamp    = r_lamp;
        n_done    = 1'b0;

        if (i_in.data.op == OP_START) begin
            if (r_phase == PH_IDLE) begin
                n_choice = i_in.data.led_select;
                n_tens   = start_tens;
                n_ones   = start_ones;
                n_lamp   = 1'b1;
                n_cnt    = 16'd0;
                if (i_in.data.negative) begin
                    n_phase = PH_MINUS;
                end else if (start_tens != 5'd0) begin
                    n_phase   = PH_TENS;
                    n_flashes = start_tens;
                end else begin
                    n_phase   = PH_ONES;
                    n_flashes = (start_ones == 4'd0) ? ZERO_FLASHES : {1'b0, start_ones};
                end
            end
        end else begin
            case (r_phase)
                PH_IDLE: ;
                PH_MINUS: begin
                    n_cnt = cnt_inc;
                    if (over_minus) begin
                        n_phase = PH_MINUS_GAP;
                        n_lamp  = 1'b0;
                        n_cnt   = 16'd0;
                    end
                end
                PH_MINUS_GAP, PH_TENS_GAP: begin
                    n_cnt = cnt_inc;
                    if (over_gap) begin
                        n_lamp = 1'b1;
                        n_cnt  = 16'd0;
                        if (r_phase == PH_MINUS_GAP && r_tens != 5'd0) begin
                            n_phase   = PH_TENS;
                            n_flashes = r_tens;
                        end else begin
                            n_phase   = PH_ONES;
                            n_flashes = (r_ones == 4'd0) ? ZERO_FLASHES : {1'b0, r_ones};
                        end
                    end
                end
                PH_TENS, PH_ONES: begin
                    n_cnt = cnt_inc;
                    if (over_flash) begin
                        n_cnt = 16'd0;
                        if (r_lamp) begin
                            n_lamp = 1'b0;
                        end else begin
                            n_flashes = flashes_dec;
                            if (flashes_dec != 5'd0) begin
                                n_lamp = 1'b1;
                            end else begin
                                n_phase = (r_phase == PH_TENS) ? PH_TENS_GAP : PH_FINAL_GAP;
                            end
                        end
                    end
                end
                PH_FINAL_GAP: begin
                    n_cnt = cnt_inc;
                    if (over_gap) begin
                        n_phase   = PH_IDLE;
                        n_lamp    = 1'b0;
                        n_cnt     = 16'd0;
                        n_flashes = 5'd0;
                        n_done    = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_lamp  = 1'b0;
                end
            endcase
        end

        n_res.led_alarm  = n_lamp && !n_choice;
        n_res.led_thermo = n_lamp && n_choice;
        n_res.busy_res   = (n_phase != PH_IDLE);
        n_res.done_res   = n_done;
    end

    // Sequencer state, advanced on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= 16'd0;
            r_flashes <= 5'd0;
            r_tens    <= 5'd0;
            r_ones    <= 4'd0;
            r_choice  <= 1'b0;
            r_lamp    <= 1'b0;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_flashes <= n_flashes;
            r_tens    <= n_tens;
            r_ones    <= n_ones;
            r_choice  <= n_choice;
            r_lamp    <= n_lamp;
        end
    end

    // Result register and skid entry; drain the skid entry first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end
        if (!out_free && in_acc) begin
            r_skid <= n_res;
        end
    end

    // Terms used by the checks
    assign flash_phase = (r_phase == PH_TENS) || (r_phase == PH_ONES);
    assign start_idle  = in_acc && (i_in.data.op == OP_START) && (r_phase == PH_IDLE);
    assign out_quiet   = !r_out.busy_res && !r_out.led_alarm && !r_out.led_thermo;

    // Checks
    `LBD_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `LBD_ASSERT_IMPLY(a_lamp_only_busy, i_clk, i_rst_n, r_lamp, r_phase != PH_IDLE)
    `LBD_ASSERT_IMPLY(a_flashes_left, i_clk, i_rst_n, flash_phase, r_flashes != 5'd0)
    `LBD_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, start_idle, r_phase != PH_IDLE)
    `LBD_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, r_out_valid && r_out.done_res, out_quiet)

endmodule
